// ----- hw/rtl/tlar_pkg.sv -----
// Shared constants and types for the triangle log2 area ratio block.
package tlar_pkg;
    localparam logic [1:0] CASE_NORMAL   = 2'd0;
    localparam logic [1:0] CASE_BOTH_0   = 2'd1;
    localparam logic [1:0] CASE_REF_0    = 2'd2;
    localparam logic [1:0] CASE_CLAMPED  = 2'd3;
    localparam int SQ_WIDTH = 192;
    localparam logic [63:0] L4_Q32 = (64'd13 << 32) + 64'd1235715261;
    typedef logic signed [SQ_WIDTH-1:0] sq_t;
endpackage

// ----- hw/rtl/tlar_log2.sv -----
// Iterative log2 of a squared magnitude: bit search then one squaring per fraction bit.
module tlar_log2 import tlar_pkg::*; #(
    parameter int FRAC = 17
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [SQ_WIDTH-1:0]    value,
    output logic [31:0]            mul_op,
    input  logic [63:0]            mul_sq,
    output logic                   done,
    output logic signed [FRAC+9:0] result
);
    localparam int PW = $clog2(SQ_WIDTH);
    localparam int CW = $clog2(FRAC + 1) + 1;
    localparam logic [1:0] ST_IDLE = 2'd0, ST_FIND = 2'd1, ST_SQ = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [SQ_WIDTH-1:0]   val_reg, val_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [31:0]           m_reg, m_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [FRAC-1:0]       frac_reg, frac_next;
    logic [32:0]           msh;

    // squaring runs on the parent's shared multiplier
    assign mul_op = m_reg;
    assign msh    = mul_sq[63:31];

    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        m_next     = m_reg;
        cnt_next   = cnt_reg;
        frac_next  = frac_reg;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    val_next   = value;
                    pos_next   = PW'(SQ_WIDTH - 1);
                    state_next = ST_FIND;
                end
            end
            ST_FIND: begin
                if (val_reg[SQ_WIDTH-1] || pos_reg == '0) begin
                    m_next     = val_reg[SQ_WIDTH-1 -: 32];
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end else begin
                    val_next = val_reg << 1;
                    pos_next = pos_reg - 1'b1;
                end
            end
            ST_SQ: begin
                if (cnt_reg == CW'(FRAC)) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    if (msh[32]) begin
                        m_next    = msh[32:1];
                        frac_next = {frac_reg[FRAC-2:0], 1'b1};
                    end else begin
                        m_next    = msh[31:0];
                        frac_next = {frac_reg[FRAC-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign result = $signed({2'b00, pos_reg, frac_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        m_reg    <= m_next;
        cnt_reg  <= cnt_next;
        frac_reg <= frac_next;
    end
endmodule

// ----- hw/rtl/triangle_log_area_ratio.sv -----
// Top level of the triangle log2 area ratio block.
//  channel | dir | tdata fields, low bit first
//  s_axis  | in  | ref_x, ref_y, ref_z, dist_x, dist_y, dist_z (32 each)
//  m_axis  | out | log2_area_ratio (OUT_FRAC_BITS+6), case_code (2), zero pad to bytes
// First two vertices of a triangle are only held and give no item.
// Third: 12 cross product and 18 squaring steps on one 34x34 multiplier, then two log2
// passes (bit search, then one squaring per fraction bit) on the same multiplier.
// m_axis_tvalid rises once the ratio is registered; if an area is zero the log2 passes
// are skipped. Input is ready again after the item is taken.
// Reset clears the vertex count and control state; held coordinates are not reset.
module triangle_log_area_ratio import tlar_pkg::*; #(
    parameter int COORD_WIDTH   = 32,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // ref_x, ref_y, ref_z, dist_x, dist_y, dist_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [((OUT_FRAC_BITS + 15) / 8) * 8 - 1:0] m_axis_tdata  // ratio, case_code
);
    localparam int OW  = OUT_FRAC_BITS + 6;
    localparam int TW  = ((OUT_FRAC_BITS + 15) / 8) * 8;
    localparam int LW  = OUT_FRAC_BITS + 11;
    localparam int DW  = 33;
    localparam int CRW = 66;
    localparam int MW  = 34;
    localparam logic [3:0] ST_IDLE = 4'd0, ST_CROSS = 4'd1, ST_SQ = 4'd2, ST_CHK = 4'd3,
        ST_LOGR = 4'd4, ST_MID = 4'd5, ST_LOGD = 4'd6, ST_FIN = 4'd7, ST_OUT = 4'd8;
    localparam logic signed [63:0] L4 =
        $signed((L4_Q32 + (64'd1 << (31 - OUT_FRAC_BITS))) >> (32 - OUT_FRAC_BITS));
    localparam logic signed [63:0] LO = -(L4 * 2);
    localparam logic signed [63:0] HI = (64'sd1 <<< (OW - 1)) - 1;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  vcnt_reg;
    logic [2:0]  idx_reg;
    logic [1:0]  part_reg;
    logic [31:0] held_reg [0:11];
    logic signed [DW-1:0]  e_reg [0:11];
    logic signed [CRW-1:0] c_reg [0:5];
    sq_t         sr_reg, sd_reg;
    logic signed [LW-1:0] lr_reg;
    logic [OW-1:0] out_val_reg;
    logic [1:0]  out_code_reg;
    logic        in_fire, surf, h_sel, lg_start, lg_done, sr_zero, sd_zero;
    logic [1:0]  kk, pp, qq;
    logic [3:0]  ia, ib;
    logic signed [CRW-1:0] c_sel;
    logic [64:0] mag;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    sq_t         sq_add;
    logic [31:0] lg_op;
    logic signed [LW-1:0] lg_res;
    logic signed [LW:0] diff, half;

    function automatic logic signed [DW-1:0] sx(input logic [31:0] v);
        return DW'($signed(v[COORD_WIDTH-1:0]));
    endfunction

    // idx: cross product index (surface*3 + k); part: multiply within it
    always_comb begin
        surf  = (idx_reg >= 3'd3);
        kk    = surf ? 2'(idx_reg - 3'd3) : idx_reg[1:0];
        pp    = (kk == 2'd2) ? 2'd0 : kk + 2'd1;
        qq    = (pp == 2'd2) ? 2'd0 : pp + 2'd1;
        h_sel = part_reg[0];
        ia    = (surf ? 4'd6 : 4'd0) + {2'b00, h_sel ? qq : pp};
        ib    = (surf ? 4'd9 : 4'd3) + {2'b00, h_sel ? pp : qq};
        c_sel = c_reg[idx_reg];
        mag   = c_sel[CRW-1] ? 65'(-c_sel) : 65'(c_sel);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CROSS: begin
                mul_a = MW'(e_reg[ia]);
                mul_b = MW'(e_reg[ib]);
            end
            ST_SQ: begin
                case (part_reg)
                    2'd0: begin
                        mul_a = {1'b0, mag[32:0]};
                        mul_b = {1'b0, mag[32:0]};
                    end
                    2'd1: begin
                        mul_a = {2'b00, mag[64:33]};
                        mul_b = {1'b0, mag[32:0]};
                    end
                    default: begin
                        mul_a = {2'b00, mag[64:33]};
                        mul_b = {2'b00, mag[64:33]};
                    end
                endcase
            end
            ST_LOGR, ST_LOGD: begin
                mul_a = {2'b00, lg_op};
                mul_b = {2'b00, lg_op};
            end
            default: ;
        endcase
        case (part_reg)
            2'd0:    sq_add = SQ_WIDTH'(prod[65:0]);
            2'd1:    sq_add = SQ_WIDTH'(prod[65:0]) << 34;
            default: sq_add = SQ_WIDTH'(prod[65:0]) << 66;
        endcase
    end
    assign prod = mul_a * mul_b;

    assign sr_zero  = (sr_reg == '0);
    assign sd_zero  = (sd_reg == '0);
    assign lg_start = (state_reg == ST_CHK && !sr_zero && !sd_zero) || (state_reg == ST_MID);

    tlar_log2 #(.FRAC(OUT_FRAC_BITS + 1)) u_log2 (
        .aclk(aclk), .aresetn(aresetn), .start(lg_start),
        .value((state_reg == ST_MID) ? sd_reg : sr_reg),
        .mul_op(lg_op), .mul_sq(prod[63:0]), .done(lg_done), .result(lg_res)
    );

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = TW'({out_code_reg, out_val_reg});
    assign diff = (LW+1)'(lg_res) - (LW+1)'(lr_reg);
    assign half = diff >>> 1;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire && vcnt_reg >= 2'd2) state_next = ST_CROSS;
            ST_CROSS: if (idx_reg == 3'd5 && part_reg == 2'd1) state_next = ST_SQ;
            ST_SQ:    if (idx_reg == 3'd5 && part_reg == 2'd2) state_next = ST_CHK;
            ST_CHK:   state_next = (sr_zero || sd_zero) ? ST_FIN : ST_LOGR;
            ST_LOGR:  if (lg_done) state_next = ST_MID;
            ST_MID:   state_next = ST_LOGD;
            ST_LOGD:  if (lg_done) state_next = ST_FIN;
            ST_FIN:   state_next = ST_OUT;
            ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vcnt_reg  <= 2'd0;
            idx_reg   <= 3'd0;
            part_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            if (in_fire)
                vcnt_reg <= (vcnt_reg >= 2'd2) ? 2'd0 : vcnt_reg + 2'd1;
            if (state_reg == ST_CROSS || state_reg == ST_SQ) begin
                if (part_reg == ((state_reg == ST_SQ) ? 2'd2 : 2'd1)) begin
                    part_reg <= 2'd0;
                    idx_reg  <= (idx_reg == 3'd5) ? 3'd0 : idx_reg + 3'd1;
                end else begin
                    part_reg <= part_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            case (vcnt_reg)
                2'd0: begin
                    for (int k = 0; k < 3; k++) begin
                        held_reg[k]     <= s_axis_tdata[32*k +: 32];
                        held_reg[6 + k] <= s_axis_tdata[32*(k+3) +: 32];
                    end
                end
                2'd1: begin
                    for (int k = 0; k < 3; k++) begin
                        held_reg[3 + k] <= s_axis_tdata[32*k +: 32];
                        held_reg[9 + k] <= s_axis_tdata[32*(k+3) +: 32];
                    end
                end
                default: begin
                    // e = v1-v0 then v2-v0, reference surface first
                    for (int k = 0; k < 3; k++) begin
                        e_reg[k]     <= sx(held_reg[3 + k]) - sx(held_reg[k]);
                        e_reg[3 + k] <= sx(s_axis_tdata[32*k +: 32]) - sx(held_reg[k]);
                        e_reg[6 + k] <= sx(held_reg[9 + k]) - sx(held_reg[6 + k]);
                        e_reg[9 + k] <= sx(s_axis_tdata[32*(k+3) +: 32]) - sx(held_reg[6 + k]);
                    end
                    sr_reg <= '0;
                    sd_reg <= '0;
                end
            endcase
        end
        if (state_reg == ST_CROSS) begin
            if (!h_sel) c_reg[idx_reg] <= CRW'(prod);
            else c_reg[idx_reg] <= c_reg[idx_reg] - CRW'(prod);
        end
        if (state_reg == ST_SQ) begin
            if (surf) sd_reg <= sd_reg + sq_add;
            else sr_reg <= sr_reg + sq_add;
        end
        if (state_reg == ST_LOGR && lg_done) lr_reg <= lg_res;
        if (state_reg == ST_FIN) begin
            if (sr_zero && sd_zero) begin
                out_val_reg <= '0; out_code_reg <= CASE_BOTH_0;
            end else if (sr_zero) begin
                out_val_reg <= OW'(L4); out_code_reg <= CASE_REF_0;
            end else if (sd_zero) begin
                out_val_reg <= OW'(LO); out_code_reg <= CASE_CLAMPED;
            end else if (64'(half) < LO) begin
                out_val_reg <= OW'(LO); out_code_reg <= CASE_CLAMPED;
            end else if (64'(half) > HI) begin
                out_val_reg <= OW'(HI); out_code_reg <= CASE_NORMAL;
            end else begin
                out_val_reg <= OW'(half); out_code_reg <= CASE_NORMAL;
            end
        end
    end
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the triangle log2 area ratio block.
module tb_top import tlar_pkg::*; ();

    typedef struct packed {
        logic signed [31:0] dz, dy, dx, rz, ry, rx;
    } vertex_t;

    typedef struct {
        logic [21:0] ratio;
        logic [1:0]  code;
    } area_result_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] MX = 32'h7fff_ffff;
    localparam logic [31:0] MN = 32'h8000_0000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;

    vertex_t      vertex_q[$];
    area_result_t ratio_q[$];
    int           errors = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           stall_on = 1'b0;
    bit           stim_done = 1'b0;

    // predictor state
    logic [31:0]  open_ref[6];
    logic [31:0]  open_dist[6];
    int           open_count = 0;

    triangle_log_area_ratio DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // ref_x, ref_y, ref_z, dist_x, dist_y, dist_z
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // log2_area_ratio[21:0], case_code[23:22]
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // squared cross product magnitude of one triangle
    function automatic sq_t cross_sq(input logic [31:0] c0[3], input logic [31:0] c1[3],
                                     input logic [31:0] c2[3]);
        sq_t e1[3], e2[3], cr[3];
        sq_t acc;
        int p, q;
        for (int k = 0; k < 3; k++) begin
            e1[k] = sq_t'(signed'(c1[k])) - sq_t'(signed'(c0[k]));
            e2[k] = sq_t'(signed'(c2[k])) - sq_t'(signed'(c0[k]));
        end
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            p = (k + 1) % 3;
            q = (k + 2) % 3;
            cr[k] = e1[p] * e2[q] - e1[q] * e2[p];
            acc = acc + cr[k] * cr[k];
        end
        return acc;
    endfunction

    // log2 with 17 fraction bits
    function automatic longint log2_q17(input sq_t s);
        int top;
        logic [63:0] mant;
        longint r;
        top = 0;
        for (int i = SQ_WIDTH - 1; i > 0; i--) begin
            if (s[i]) begin
                top = i;
                break;
            end
        end
        mant = '0;
        for (int i = 0; i < 32; i++)
            mant = {mant[62:0], (top - i >= 0) ? s[top - i] : 1'b0};
        r = top;
        for (int i = 0; i < 17; i++) begin
            mant = (mant * mant) >> 31;
            r = r * 2;
            if (mant >= 64'h1_0000_0000) begin
                r = r + 1;
                mant = mant >> 1;
            end
        end
        return r;
    endfunction

    task automatic predict_vertex(input vertex_t v);
        logic [31:0] r0[3], r1[3], r2[3], d0[3], d1[3], d2[3];
        sq_t sr, sd;
        longint l4, lo, diff, val;
        area_result_t res;
        if (open_count < 2) begin
            open_ref[open_count*3+0] = v.rx;
            open_ref[open_count*3+1] = v.ry;
            open_ref[open_count*3+2] = v.rz;
            open_dist[open_count*3+0] = v.dx;
            open_dist[open_count*3+1] = v.dy;
            open_dist[open_count*3+2] = v.dz;
            open_count++;
            return;
        end
        open_count = 0;
        for (int k = 0; k < 3; k++) begin
            r0[k] = open_ref[k];
            r1[k] = open_ref[3+k];
            d0[k] = open_dist[k];
            d1[k] = open_dist[3+k];
        end
        r2 = '{v.rx, v.ry, v.rz};
        d2 = '{v.dx, v.dy, v.dz};
        sr = cross_sq(r0, r1, r2);
        sd = cross_sq(d0, d1, d2);
        l4 = longint'((L4_Q32 + 64'd32768) >> 16);
        lo = -2 * l4;
        if (sr == 0) begin
            val = (sd == 0) ? 0 : l4;
            res.code = (sd == 0) ? CASE_BOTH_0 : CASE_REF_0;
        end else if (sd == 0) begin
            val = lo;
            res.code = CASE_CLAMPED;
        end else begin
            diff = log2_q17(sd) - log2_q17(sr);
            val = diff >>> 1;
            res.code = CASE_NORMAL;
            if (val < lo) begin
                val = lo;
                res.code = CASE_CLAMPED;
            end else if (val > (1 << 21) - 1) begin
                val = (1 << 21) - 1;
            end
        end
        res.ratio = val[21:0];
        ratio_q.push_back(res);
    endtask

    // driver
    always @(posedge aclk) begin
        vertex_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_vertex(vertex_t'(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0 || vertex_q.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    nxt = vertex_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= nxt;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                    end
                end
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        area_result_t exp_res;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (ratio_q.size() == 0) begin
                    $display("%0t: unexpected item, actual ratio=%h code=%0d", $time,
                             m_axis_tdata[21:0], m_axis_tdata[23:22]);
                    errors++;
                end else begin
                    exp_res = ratio_q.pop_front();
                    if (m_axis_tdata[21:0] !== exp_res.ratio) begin
                        $display("%0t: ratio mismatch, expected %h actual %h", $time,
                                 exp_res.ratio, m_axis_tdata[21:0]);
                        errors++;
                    end
                    if (m_axis_tdata[23:22] !== exp_res.code) begin
                        $display("%0t: case code mismatch, expected %0d actual %0d", $time,
                                 exp_res.code, m_axis_tdata[23:22]);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
            end else begin
                stall_on = !stall_on;
                stall_left = stall_on ? $urandom_range(0, 300) : $urandom_range(0, 2000);
            end
            m_axis_tready <= stall_on ? ($urandom_range(0, 7) == 0) : 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 64)) - 32);
            2: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        v = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        return v;
    endfunction

    task automatic add_tri(input vertex_t a, input vertex_t b, input vertex_t c);
        vertex_q.push_back(a);
        vertex_q.push_back(b);
        vertex_q.push_back(c);
    endtask

    initial begin
        vertex_t a, b, c;
        // both areas zero
        add_tri('0, '0, '0);
        // reference degenerate, distorted not
        add_tri('0, {96'd0, 96'd0} | {32'd0, 32'd0, 32'h10000, 96'd0},
                {32'd0, 32'h10000, 32'd0, 96'd0});
        // distorted degenerate
        add_tri('0, {96'd0, 32'd0, 32'd0, 32'h10000}, {96'd0, 32'd0, 32'h10000, 32'd0});
        // extremes: huge distorted, unit reference (saturation)
        add_tri({MN, MN, MN, 32'd0, 32'd0, 32'd0},
                {MX, MN, MX, 32'd0, 32'd0, 32'd1},
                {MN, MX, MX, 32'd0, 32'd1, 32'd0});
        // huge reference, unit distorted (below floor)
        add_tri({32'd0, 32'd0, 32'd0, MN, MN, MN},
                {32'd0, 32'd0, 32'd1, MX, MN, MX},
                {32'd0, 32'd1, 32'd0, MN, MX, MX});
        // equal areas, all-ones and mixed
        a = {6{32'hffff_ffff}};
        b = {MX, MN, MX, MX, MN, MX};
        c = {MN, MX, MN, MN, MX, MN};
        add_tri(a, b, c);
        add_tri(c, a, b);
        // collinear reference
        add_tri({96'd5, 32'd0, 32'd0, 32'd0}, {96'd7, 32'd2, 32'd2, 32'd2},
                {96'd9, 32'd4, 32'd4, 32'd4});
        for (int t = 0; t < 530; t++) begin
            a = rand_vertex();
            b = rand_vertex();
            c = rand_vertex();
            case ($urandom_range(0, 9))
                0: c = a;
                1: {c.rz, c.ry, c.rx} = {b.rz, b.ry, b.rx};
                2: {c.dz, c.dy, c.dx} = {a.dz, a.dy, a.dx};
                3: {b.dz, b.dy, b.dx, c.dz, c.dy, c.dx} = {b.rz, b.ry, b.rx, c.rz, c.ry, c.rx};
                default: ;
            endcase
            add_tri(a, b, c);
        end
        vertex_q.push_back(rand_vertex());
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait (vertex_q.size() == 0);
        @(posedge aclk);
        wait (!s_axis_tvalid && ratio_q.size() == 0);
        repeat (600) @(posedge aclk);
        if (errors == 0 && ratio_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
